### hw/rtl/stack_with_positional_access_assert.svh
// Assertion macros for the stack block.
// Each macro takes a label, a trigger expression and a consequent.
`ifndef STACK_WITH_POSITIONAL_ACCESS_ASSERT_SVH
`define STACK_WITH_POSITIONAL_ACCESS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the trigger
`define SWPA_ASSERT_NOW(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("stack assertion failed");

// consequent must hold in the cycle after the trigger
`define SWPA_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("stack assertion failed");

`else

`define SWPA_ASSERT_NOW(lbl, trig, cons)
`define SWPA_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

### hw/rtl/swpa_pkg.sv
package swpa_pkg;

  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 8;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 8;
  localparam int LIM_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  // read tree: groups of cells ORed and registered, then groups ORed
  localparam int GRP      = 16;
  localparam int NGRP     = (DEPTH + GRP - 1) / GRP;
  localparam int PAD_CELLS = NGRP * GRP;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CHANGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [DATA_W-1:0]  value;
    logic        [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  data_out;
    logic        [CNT_W-1:0]   fill_count;
  } out_item_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic             shift_down;
    logic             shift_up;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] sel_idx;
  } cell_ctrl_t;

endpackage

### hw/rtl/swpa_cell.sv
module swpa_cell (
  input  logic                        clk,
  input  swpa_pkg::cell_ctrl_t        ctrl,
  input  logic [swpa_pkg::IDX_W-1:0]  idx,
  input  logic [swpa_pkg::DATA_W-1:0] above,
  input  logic [swpa_pkg::DATA_W-1:0] below,
  input  logic [swpa_pkg::DATA_W-1:0] wdata,
  output logic [swpa_pkg::DATA_W-1:0] q,
  output logic [swpa_pkg::DATA_W-1:0] rd_q
);

  logic [swpa_pkg::DATA_W-1:0] data_r;
  logic                        hit;

  assign hit = (ctrl.sel_idx == idx);

  always_ff @(posedge clk) begin
    if (ctrl.shift_down) begin
      data_r <= above;
    end else if (ctrl.shift_up) begin
      data_r <= below;
    end else if (ctrl.wr_en && hit) begin
      data_r <= wdata;
    end
  end

  assign q    = data_r;
  assign rd_q = (ctrl.rd_en && hit) ? data_r : '0;

endmodule

### hw/rtl/swpa_rd_tree.sv
module swpa_rd_tree (
  input  logic                        clk,
  input  logic [swpa_pkg::DATA_W-1:0] cell_rd [swpa_pkg::PAD_CELLS],
  output logic [swpa_pkg::DATA_W-1:0] rd_data
);

  logic [swpa_pkg::DATA_W-1:0] grp_nxt [swpa_pkg::NGRP];
  logic [swpa_pkg::DATA_W-1:0] grp_r   [swpa_pkg::NGRP];

  always_comb begin
    for (int g = 0; g < swpa_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < swpa_pkg::GRP; k++) begin
        grp_nxt[g] = grp_nxt[g] | cell_rd[g * swpa_pkg::GRP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < swpa_pkg::NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // at most one cell drives a nonzero word, so OR acts as the select
  always_comb begin
    rd_data = '0;
    for (int g = 0; g < swpa_pkg::NGRP; g++) begin
      rd_data = rd_data | grp_r[g];
    end
  end

endmodule

### hw/rtl/stack_with_positional_access.sv
// LIFO stack of 32-bit words held in a row of cells, cell 0 being the top. Push shifts
// the row down and pop shifts it up in the accepting cycle. An item is taken when start
// is high and busy is low; its result appears on out_item for exactly one cycle, marked
// by out_valid, in the cycle after the item is taken (push, pop, change, and any item
// with an error status), or for a valid peek after the group registers of the
// two-level OR tree over the cell row and the output register, with busy high for one
// cycle. The result cannot be stalled: the receiver must take it in that cycle. The
// capacity register is written over the cfg port, always ready; the user must write it
// only while the block is idle, not enforced by the block; values above the row length
// act as the row length. Entries need no clearing after reset.
`include "stack_with_positional_access_assert.svh"

module stack_with_positional_access (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  swpa_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output swpa_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [swpa_pkg::CAP_W-1:0] cfg_data
);

  typedef enum logic {S_IDLE, S_PEEK} state_t;

  state_t                        state_r, state_nxt;
  logic [swpa_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic [swpa_pkg::CAP_W-1:0]    cap_r;
  logic                          out_valid_r, out_valid_nxt;
  swpa_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                          accept;
  logic [swpa_pkg::LIM_W-1:0]    fill_ext, cap_ext, depth_l, limit, pos_ext;
  logic                          full, empty, pos_bad;
  swpa_pkg::cell_ctrl_t          ctrl;

  logic [swpa_pkg::DATA_W-1:0]   cell_q   [swpa_pkg::DEPTH];
  logic [swpa_pkg::DATA_W-1:0]   cell_rd  [swpa_pkg::PAD_CELLS];
  logic [swpa_pkg::DATA_W-1:0]   rd_data;

  assign busy      = (state_r == S_PEEK);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign fill_ext = swpa_pkg::LIM_W'(fill_r);
  assign cap_ext  = swpa_pkg::LIM_W'(cap_r);
  assign depth_l  = swpa_pkg::LIM_W'(swpa_pkg::DEPTH);
  assign limit    = (cap_ext > depth_l) ? depth_l : cap_ext;
  assign pos_ext  = swpa_pkg::LIM_W'(in_item.position);
  assign full     = (fill_ext >= limit);
  assign empty    = (fill_r == '0);
  assign pos_bad  = (in_item.position == '0) || (pos_ext > fill_ext);

  always_comb begin
    ctrl.shift_down = accept && (in_item.opcode == swpa_pkg::OP_PUSH) && !full;
    ctrl.shift_up   = accept && (in_item.opcode == swpa_pkg::OP_POP) && !empty;
    ctrl.wr_en      = accept && (in_item.opcode == swpa_pkg::OP_CHANGE) && !pos_bad;
    ctrl.rd_en      = (in_item.opcode == swpa_pkg::OP_PEEK) && !pos_bad;
    ctrl.sel_idx    = swpa_pkg::IDX_W'(pos_ext - swpa_pkg::LIM_W'(1));
  end

  for (genvar i = 0; i < swpa_pkg::DEPTH; i++) begin : g_cell
    logic [swpa_pkg::DATA_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = in_item.value;
    end else begin : g_mid_a
      assign above = cell_q[i-1];
    end
    if (i == swpa_pkg::DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = cell_q[i+1];
    end
    swpa_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (swpa_pkg::IDX_W'(i)),
      .above (above),
      .below (below),
      .wdata (in_item.value),
      .q     (cell_q[i]),
      .rd_q  (cell_rd[i])
    );
  end

  for (genvar i = swpa_pkg::DEPTH; i < swpa_pkg::PAD_CELLS; i++) begin : g_pad
    assign cell_rd[i] = '0;
  end

  swpa_rd_tree u_rd_tree (
    .clk     (clk),
    .cell_rd (cell_rd),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (state_r == S_PEEK) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.status     = swpa_pkg::ST_OK;
      out_item_nxt.data_out   = rd_data;
      out_item_nxt.fill_count = swpa_pkg::CNT_W'(fill_r);
      state_nxt               = S_IDLE;
    end else if (accept) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.status   = swpa_pkg::ST_OK;
      out_item_nxt.data_out = '0;
      case (in_item.opcode)
        swpa_pkg::OP_PUSH: begin
          if (full) begin
            out_item_nxt.status = swpa_pkg::ST_OVERFLOW;
          end else begin
            fill_nxt = swpa_pkg::FILL_W'(fill_r + 1'b1);
          end
        end
        swpa_pkg::OP_POP: begin
          if (empty) begin
            out_item_nxt.status = swpa_pkg::ST_UNDERFLOW;
          end else begin
            fill_nxt              = swpa_pkg::FILL_W'(fill_r - 1'b1);
            out_item_nxt.data_out = cell_q[0];
          end
        end
        swpa_pkg::OP_PEEK: begin
          if (pos_bad) begin
            out_item_nxt.status = swpa_pkg::ST_BADPOS;
          end else begin
            // wait for the read tree
            out_valid_nxt = 1'b0;
            state_nxt     = S_PEEK;
          end
        end
        swpa_pkg::OP_CHANGE: begin
          if (pos_bad) begin
            out_item_nxt.status = swpa_pkg::ST_BADPOS;
          end else begin
            out_item_nxt.data_out = in_item.value;
          end
        end
        default: begin
          out_item_nxt.status = swpa_pkg::ST_OK;
        end
      endcase
      out_item_nxt.fill_count = swpa_pkg::CNT_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cap_r       <= swpa_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
    out_item_r <= out_item_nxt;
  end

  `SWPA_ASSERT_NEXT(a_peek_one_cycle, busy, !busy && out_valid)
  `SWPA_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= swpa_pkg::FILL_W'(swpa_pkg::DEPTH))
  `SWPA_ASSERT_NEXT(a_underflow, accept && (in_item.opcode == swpa_pkg::OP_POP) && empty,
                    out_valid && (out_item.status == swpa_pkg::ST_UNDERFLOW))
  `SWPA_ASSERT_NEXT(a_push_fill, ctrl.shift_down,
                    fill_r == swpa_pkg::FILL_W'($past(fill_r) + 1'b1))

endmodule

### tb/stack_checker.sv
module stack_checker
  import swpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  out_item_t        out_item,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output logic [3:0]       status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] words [DEPTH];
  int unsigned       level;
  logic [CAP_W-1:0]  cap_reg;
  out_item_t         awaited_results [$];

  // apply one operation to the shadow stack and return its result
  function automatic out_item_t stack_op_result(in_item_t it);
    out_item_t   r;
    int unsigned lim;
    int unsigned slot;
    r.status   = ST_OK;
    r.data_out = '0;
    lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    case (it.opcode)
      OP_PUSH: begin
        if (level >= lim) begin
          r.status = ST_OVERFLOW;
        end else begin
          words[level] = it.value;
          level++;
        end
      end
      OP_POP: begin
        if (level == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          level--;
          r.data_out = words[level];
        end
      end
      default: begin
        if (it.position == 0 || it.position > level) begin
          r.status = ST_BADPOS;
        end else begin
          slot = level - it.position;
          if (it.opcode == OP_CHANGE) words[slot] = it.value;
          r.data_out = words[slot];
        end
      end
    endcase
    r.fill_count = CNT_W'(level);
    return r;
  endfunction

  initial begin
    fail_count  = 0;
    pending     = 0;
    checked     = 0;
    status_seen = '0;
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      level   = 0;
      cap_reg = CAP_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got status %0d data %0d fill %0d",
                   $time, out_item.status, out_item.data_out, out_item.fill_count);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          status_seen[want.status] = 1'b1;
          if (out_item !== want) begin
            fail_count++;
            $display("%0t: result mismatch: expected status %0d data %0d fill %0d, got status %0d data %0d fill %0d",
                     $time, want.status, want.data_out, want.fill_count,
                     out_item.status, out_item.data_out, out_item.fill_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (start && !busy) awaited_results.push_back(stack_op_result(in_item));
    end
    pending = awaited_results.size();
  end

endmodule

### tb/tb.sv
module tb;
  import swpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FILLING, DRAINING, MIXED} trend_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  in_item_t         in_item   = '0;
  logic             cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_ready;

  int               fail_count;
  int               pending;
  int               checked;
  logic [3:0]       status_seen;

  int unsigned      level_guess = 0;
  logic [CAP_W-1:0] cap_now     = CAP_RESET;
  int               idle_pct    = 0;
  int               cap_writes  = 0;

  stack_with_positional_access dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  stack_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .status_seen (status_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL stack_with_positional_access");
    $finish;
  end

  // called right after a rising edge; returns after the accepting edge and any idle gap
  task automatic issue(input op_t op, input logic [DATA_W-1:0] val, input logic [POS_W-1:0] pos);
    in_item_t    it;
    int unsigned lim;
    it.opcode   = op;
    it.value    = val;
    it.position = pos;
    in_item <= it;
    start   <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    lim = (cap_now > DEPTH) ? DEPTH : cap_now;
    if (op == OP_PUSH && level_guess < lim) level_guess++;
    if (op == OP_POP && level_guess > 0) level_guess--;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(posedge clk);
    cfg_data  <= c;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cap_now = c;
    cap_writes++;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly positions inside the stack, the rest on and past the edges
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) return POS_W'($urandom_range(level_guess > 0 ? level_guess : 1, 1));
    if (r == 7) return '0;
    if (r == 8) return POS_W'(level_guess + 1);
    return POS_W'($urandom_range(255, 0));
  endfunction

  task automatic run_phase(input int n, input logic [CAP_W-1:0] c, input int pct);
    trend_t      trend;
    int          left;
    int unsigned r;
    op_t         op;
    trend = MIXED;
    left  = 0;
    write_capacity(c);
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        trend = trend_t'($urandom_range(2));
        left  = $urandom_range(150, 20);
      end
      left--;
      r = $urandom_range(99);
      case (trend)
        FILLING:  op = (r < 85) ? OP_PUSH : (r < 90) ? OP_POP : (r < 95) ? OP_PEEK : OP_CHANGE;
        DRAINING: op = (r < 85) ? OP_POP : (r < 90) ? OP_PUSH : (r < 95) ? OP_PEEK : OP_CHANGE;
        default:  op = (r < 30) ? OP_PUSH : (r < 55) ? OP_POP : (r < 80) ? OP_PEEK : OP_CHANGE;
      endcase
      issue(op, rand_word(), pick_position());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack corners, then position corners on a four-entry stack and popping it past empty
    issue(OP_POP, '0, 8'd0);
    issue(OP_PEEK, '0, 8'd1);
    issue(OP_CHANGE, 32'h1, 8'd0);
    issue(OP_PUSH, 32'h7FFF_FFFF, 8'd0);
    issue(OP_PUSH, 32'h8000_0000, 8'd255);
    issue(OP_PUSH, 32'h0000_0000, 8'd0);
    issue(OP_PUSH, 32'hFFFF_FFFF, 8'd0);
    issue(OP_PEEK, '0, 8'd1);
    issue(OP_PEEK, '0, 8'd2);
    issue(OP_PEEK, '0, 8'd4);
    issue(OP_PEEK, '0, 8'd0);
    issue(OP_PEEK, '0, 8'd5);
    issue(OP_PEEK, '0, 8'd255);
    issue(OP_CHANGE, 32'h1234_5678, 8'd2);
    issue(OP_CHANGE, 32'hAAAA_AAAA, 8'd4);
    issue(OP_CHANGE, 32'h5555_5555, 8'd5);
    issue(OP_PEEK, '0, 8'd2);
    issue(OP_PEEK, '0, 8'd4);
    repeat (5) issue(OP_POP, '0, 8'd0);

    // the stack carries over between phases, so a lowered capacity can start below the fill
    run_phase(250, 8'd128, 0);
    run_phase(250, 8'd1, 88);
    run_phase(250, 8'd255, 0);
    run_phase(250, 8'd0, 27);
    run_phase(250, 8'($urandom_range(8, 2)), 88);
    run_phase(250, 8'($urandom_range(127, 9)), 0);

    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d results across %0d capacity writes and three idle patterns;",
             checked, cap_writes);
    $display("status codes seen (bit per code, ok in bit 0): %b", status_seen);
    if (fail_count == 0) begin
      $display("PASS stack_with_positional_access");
    end else begin
      $display("FAIL stack_with_positional_access");
    end
    $finish;
  end

endmodule
